>>> design/olt_pkg.sv
// ---------------------------------------------------------------------------
// olt_pkg: shared types and constants for the ordered list table
// operation and status codes, controller states, command and status bundles
// ---------------------------------------------------------------------------
package olt_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 8;
  localparam int STS_W  = 3;
  localparam int FIDX_W = 6;
  localparam int LEN_W  = 7;

  localparam int IN_FIELDS_W  = OP_W + POS_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STS_W + VAL_W + FIDX_W + LEN_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_BADPOS   = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_RD_WAIT,
    S_FIND_RD,
    S_FIND_CHK,
    S_DONE
  } state_t;

  // read address source
  typedef enum logic [1:0] {
    RD_POS,
    RD_IDX,
    RD_IDX_DN,
    RD_IDX_UP
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    idx_top;
    logic    idx_pos;
    logic    idx_zero;
    logic    idx_inc;
    logic    idx_dec;
    logic    mem_rd;
    rd_sel_t rd_sel;
    logic    mem_wr;
    logic    wr_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_load;
    status_t st_code;
    logic    rd_cap;
    logic    fi_cap;
    logic    out_load;
  } olt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic pos_last;
    logic ins_next_pos;
    logic del_last;
    logic idx_last;
    logic hit;
    logic out_free;
  } olt_sts_t;

endpackage

>>> design/olt_ctrl.sv
// ---------------------------------------------------------------------------
// olt_ctrl: operation sequencer
// walks insert/delete shifts and find scans one entry per step
// ---------------------------------------------------------------------------
module olt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  olt_pkg::olt_sts_t sts,
  output olt_pkg::olt_cmd_t cmd
);
  import olt_pkg::*;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_INSERT: begin
            if (sts.full || sts.pos_gt_cnt) state_nxt = S_DONE;
            else if (!sts.pos_ge_cnt)       state_nxt = S_SH_RD;
            else                            state_nxt = S_INS_WR;
          end
          OP_DELETE: begin
            if (sts.empty || sts.pos_ge_cnt || sts.pos_last) state_nxt = S_DONE;
            else                                             state_nxt = S_SH_RD;
          end
          OP_READ: begin
            if (sts.pos_ge_cnt) state_nxt = S_DONE;
            else                state_nxt = S_RD_WAIT;
          end
          OP_FIND: begin
            if (sts.empty) state_nxt = S_DONE;
            else           state_nxt = S_FIND_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        if (sts.op == OP_INSERT) begin
          state_nxt = sts.ins_next_pos ? S_INS_WR : S_SH_RD;
        end else begin
          state_nxt = sts.del_last ? S_DONE : S_SH_RD;
        end
      end
      S_INS_WR:  state_nxt = S_DONE;
      S_RD_WAIT: state_nxt = S_DONE;
      S_FIND_RD: state_nxt = S_FIND_CHK;
      S_FIND_CHK: begin
        if (sts.hit || sts.idx_last) state_nxt = S_DONE;
        else                         state_nxt = S_FIND_RD;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.rd_sel  = RD_IDX;
    cmd.st_code = STS_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_INSERT: begin
            if (sts.full) begin
              cmd.st_load = 1'b1;
              cmd.st_code = STS_FULL;
            end else if (sts.pos_gt_cnt) begin
              cmd.st_load = 1'b1;
              cmd.st_code = STS_BADPOS;
            end else begin
              cmd.idx_top = 1'b1;
            end
          end
          OP_DELETE: begin
            if (sts.empty) begin
              cmd.st_load = 1'b1;
              cmd.st_code = STS_EMPTY;
            end else if (sts.pos_ge_cnt) begin
              cmd.st_load = 1'b1;
              cmd.st_code = STS_BADPOS;
            end else if (sts.pos_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.idx_pos = 1'b1;
            end
          end
          OP_READ: begin
            if (sts.pos_ge_cnt) begin
              cmd.st_load = 1'b1;
              cmd.st_code = STS_BADPOS;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = RD_POS;
            end
          end
          OP_FIND: begin
            if (sts.empty) begin
              cmd.st_load = 1'b1;
              cmd.st_code = STS_NOTFOUND;
            end else begin
              cmd.idx_zero = 1'b1;
            end
          end
          default: cmd.st_load = 1'b0;
        endcase
      end
      S_SH_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = (sts.op == OP_INSERT) ? RD_IDX_DN : RD_IDX_UP;
      end
      S_SH_WR: begin
        cmd.mem_wr = 1'b1;
        if (sts.op == OP_INSERT) begin
          cmd.idx_dec = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.cnt_dec = sts.del_last;
        end
      end
      S_INS_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_RD_WAIT: begin
        cmd.rd_cap = 1'b1;
      end
      S_FIND_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_IDX;
      end
      S_FIND_CHK: begin
        if (sts.hit) begin
          cmd.fi_cap = 1'b1;
        end else if (sts.idx_last) begin
          cmd.st_load = 1'b1;
          cmd.st_code = STS_NOTFOUND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd.load = 1'b0;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted item did not start execution");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> (state_r == S_SH_WR || state_r == S_INS_WR))
    else $error("memory write outside a write step");

  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("result loaded without returning to idle");

endmodule

>>> design/olt_dp.sv
// ---------------------------------------------------------------------------
// olt_dp: list storage, length counter, walk index and result register
// ---------------------------------------------------------------------------
module olt_dp #(
  parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [olt_pkg::OP_W-1:0]      in_operation,
  input  logic [olt_pkg::POS_W-1:0]     in_position,
  input  logic [olt_pkg::VAL_W-1:0]     in_value,
  input  olt_pkg::olt_cmd_t             cmd,
  output olt_pkg::olt_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [olt_pkg::STS_W-1:0]     out_status,
  output logic [olt_pkg::VAL_W-1:0]     out_read_value,
  output logic [olt_pkg::FIDX_W-1:0]    out_found_index,
  output logic [olt_pkg::LEN_W-1:0]     out_list_length
);
  import olt_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CMPW-1:0] CAP_E = CMPW'(CAPACITY);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  status_t          st_r;
  logic [VAL_W-1:0] rdv_r;
  logic [CW-1:0]    fidx_r;

  logic             ovalid_r, ovalid_nxt;
  logic [STS_W-1:0] ost_r;
  logic [VAL_W-1:0] ordv_r;
  logic [FIDX_W-1:0] ofidx_r;
  logic [LEN_W-1:0] olen_r;

  logic [CMPW-1:0]  pos_e, cnt_e, idx_e, fidx_e, rd_e;
  logic [AW-1:0]    rd_addr, wr_addr;

  assign pos_e  = CMPW'(pos_r);
  assign cnt_e  = CMPW'(cnt_r);
  assign idx_e  = CMPW'(idx_r);
  assign fidx_e = CMPW'(fidx_r);

  // status toward the controller
  always_comb begin
    sts.op           = op_r;
    sts.full         = (cnt_e >= CAP_E);
    sts.empty        = (cnt_r == '0);
    sts.pos_gt_cnt   = (pos_e > cnt_e);
    sts.pos_ge_cnt   = (pos_e >= cnt_e);
    sts.pos_last     = (pos_e + CMPW'(1) == cnt_e);
    sts.ins_next_pos = (idx_e - CMPW'(1) == pos_e);
    sts.del_last     = (idx_e + CMPW'(2) >= cnt_e);
    sts.idx_last     = (idx_e + CMPW'(1) >= cnt_e);
    sts.hit          = (rdata_r == val_r);
    sts.out_free     = !ovalid_r || out_ready;
  end

  // address selection
  always_comb begin
    case (cmd.rd_sel)
      RD_POS:    rd_e = pos_e;
      RD_IDX_DN: rd_e = idx_e - CMPW'(1);
      RD_IDX_UP: rd_e = idx_e + CMPW'(1);
      default:   rd_e = idx_e;
    endcase
  end

  assign rd_addr = rd_e[AW-1:0];
  assign wr_addr = idx_e[AW-1:0];

  // list storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= cmd.wr_val ? val_r : rdata_r;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // walk index and length
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_top)       idx_nxt = cnt_r;
    else if (cmd.idx_pos)  idx_nxt = pos_e[CW-1:0];
    else if (cmd.idx_zero) idx_nxt = '0;
    else if (cmd.idx_inc)  idx_nxt = idx_r + CW'(1);
    else if (cmd.idx_dec)  idx_nxt = idx_r - CW'(1);

    cnt_nxt = cnt_r;
    if (cmd.cnt_inc)      cnt_nxt = cnt_r + CW'(1);
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - CW'(1);

    ovalid_nxt = ovalid_r;
    if (cmd.out_load)   ovalid_nxt = 1'b1;
    else if (out_ready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // item capture and per-item result
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      pos_r  <= in_position;
      val_r  <= in_value;
      st_r   <= STS_OK;
      rdv_r  <= '0;
      fidx_r <= '0;
    end else begin
      if (cmd.st_load) st_r   <= cmd.st_code;
      if (cmd.rd_cap)  rdv_r  <= rdata_r;
      if (cmd.fi_cap)  fidx_r <= idx_r;
    end
    if (cmd.out_load) begin
      ost_r   <= st_r;
      ordv_r  <= rdv_r;
      ofidx_r <= fidx_e[FIDX_W-1:0];
      olen_r  <= cnt_e[LEN_W-1:0];
    end
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ost_r;
  assign out_read_value  = ordv_r;
  assign out_found_index = ofidx_r;
  assign out_list_length = olen_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_e <= CAP_E)
    else $error("list length above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_inc || cmd.cnt_dec) |=> (cnt_r != $past(cnt_r)))
    else $error("length update lost");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.cnt_inc && !cmd.cnt_dec) |=> $stable(cnt_r))
    else $error("length changed without a command");

endmodule

>>> design/ordered_list_table_core.sv
// ---------------------------------------------------------------------------
// ordered_list_table_core: bounded ordered list of bytes
// insert, delete, read and find over a stored list with one result per item
// ---------------------------------------------------------------------------
// steps: after an execution step a rejected item goes to the result step, a read
//   does a registered read, an insert shifts the tail up one entry from the end
//   and writes the value, a delete shifts the tail down, a find scans from index 0
//   (the whole list on a miss); the result step waits for a free output register
// flow: one item at a time; each shifted entry is a registered read, then a write
// reset: rst_n synchronous active low clears the length and the result valid;
//   list storage is not cleared, entries at or beyond the length are never read
// ---------------------------------------------------------------------------
module ordered_list_table_core #(
  parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // operation [1:0], position [8:2], value [16:9]
  input  logic [olt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // status [2:0], read_value [10:3], found_index [16:11], list_length [23:17]
  output logic [olt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready
);
  import olt_pkg::*;

  olt_cmd_t cmd;
  olt_sts_t sts;

  // unpacked input item fields
  logic [OP_W-1:0]   in_operation;
  logic [POS_W-1:0]  in_position;
  logic [VAL_W-1:0]  in_value;

  // result item fields
  logic [STS_W-1:0]  out_status;
  logic [VAL_W-1:0]  out_read_value;
  logic [FIDX_W-1:0] out_found_index;
  logic [LEN_W-1:0]  out_list_length;

  assign in_operation = in_tdata[OP_W-1:0];
  assign in_position  = in_tdata[OP_W +: POS_W];
  assign in_value     = in_tdata[OP_W+POS_W +: VAL_W];

  // zero fill up to whole bytes
  assign out_tdata = OUT_TDATA_W'({out_list_length, out_found_index,
                                   out_read_value, out_status});

  // sequencer: one operation in flight, result parked in the output register
  olt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, length, walk index and the output register
  olt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found_index (out_found_index),
    .out_list_length (out_list_length)
  );

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for ordered_list_table_core
// drives insert, delete, read and find items over the input stream, takes each
// result from a typed table row or a shadow copy of the list, checks each output
// item field by field, with random idle gaps on the input and stalls on the output
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import olt_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RAND_ITEMS   = 1600;
  // watchdog limit for the whole run
  localparam int CYCLE_LIMIT  = 2_000_000;
  // idle margin kept after the last result has drained
  localparam int DRAIN_CYCLES = 2 * CAP + 20;

  // traffic shapes for the random part
  typedef enum {
    MIX_GROW,
    MIX_SHRINK,
    MIX_STEADY,
    MIX_NOISE
  } mix_t;

  // one result item as the block reports it
  typedef struct {
    status_t           sts;
    logic [VAL_W-1:0]  rd;
    logic [FIDX_W-1:0] fidx;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic [6:0]        rpt;
    logic              typed;
    status_t           sts;
    logic [VAL_W-1:0]  rd;
    logic [FIDX_W-1:0] fidx;
    logic [LEN_W-1:0]  len;
  } dir_row_t;

  // list contents after some groups of rows are noted in the comment above them
  dir_row_t dir_rows [29] = '{
    // empty list: every operation that needs an entry is refused
    '{OP_FIND,   7'd0,   8'h00, 7'd1,  1'b1, STS_NOTFOUND, 8'h00, 6'd0,  7'd0},
    '{OP_DELETE, 7'd0,   8'h00, 7'd1,  1'b1, STS_EMPTY,    8'h00, 6'd0,  7'd0},
    // empty is reported before a bad position
    '{OP_DELETE, 7'd64,  8'h00, 7'd1,  1'b1, STS_EMPTY,    8'h00, 6'd0,  7'd0},
    '{OP_READ,   7'd0,   8'h00, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd0},
    '{OP_INSERT, 7'd1,   8'h00, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd0},
    // build a5 ff 00
    '{OP_INSERT, 7'd0,   8'hFF, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd1},
    '{OP_INSERT, 7'd1,   8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd2},
    '{OP_INSERT, 7'd0,   8'hA5, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd3},
    // reads ignore the value field
    '{OP_READ,   7'd0,   8'h5A, 7'd1,  1'b1, STS_OK,       8'hA5, 6'd0,  7'd3},
    '{OP_READ,   7'd2,   8'hFF, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd3},
    '{OP_READ,   7'd3,   8'h00, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd3},
    '{OP_READ,   7'd127, 8'h00, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd3},
    // find ignores the position field
    '{OP_FIND,   7'd127, 8'hFF, 7'd1,  1'b1, STS_OK,       8'h00, 6'd1,  7'd3},
    '{OP_FIND,   7'd0,   8'h5A, 7'd1,  1'b1, STS_NOTFOUND, 8'h00, 6'd0,  7'd3},
    '{OP_INSERT, 7'd4,   8'h11, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd3},
    '{OP_DELETE, 7'd3,   8'hFF, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd3},
    // middle delete closes the gap: a5 00
    '{OP_DELETE, 7'd1,   8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd2},
    '{OP_READ,   7'd1,   8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd2},
    '{OP_FIND,   7'd0,   8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd1,  7'd2},
    // fill at the head up to capacity: 3c x62, a5, 00
    '{OP_INSERT, 7'd0,   8'h3C, 7'd62, 1'b0, STS_OK,       8'h00, 6'd0,  7'd0},
    '{OP_INSERT, 7'd0,   8'h77, 7'd1,  1'b1, STS_FULL,     8'h00, 6'd0,  7'd64},
    // full is reported before a bad position
    '{OP_INSERT, 7'd65,  8'h77, 7'd1,  1'b1, STS_FULL,     8'h00, 6'd0,  7'd64},
    '{OP_FIND,   7'd0,   8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd63, 7'd64},
    '{OP_READ,   7'd63,  8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd64},
    '{OP_READ,   7'd64,  8'h00, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd64},
    '{OP_DELETE, 7'd64,  8'h00, 7'd1,  1'b1, STS_BADPOS,   8'h00, 6'd0,  7'd64},
    // delete of the last entry
    '{OP_DELETE, 7'd63,  8'h00, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd63},
    '{OP_FIND,   7'd0,   8'hA5, 7'd1,  1'b1, STS_OK,       8'h00, 6'd62, 7'd63},
    // duplicates: the lowest index wins
    '{OP_FIND,   7'd0,   8'h3C, 7'd1,  1'b1, STS_OK,       8'h00, 6'd0,  7'd63}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;

  // shadow copy of the list, advanced once per accepted item
  logic [VAL_W-1:0] shadow_entries [CAP];
  int unsigned      shadow_len;
  int unsigned      peak_len;

  list_result_t pending_results [$];

  int errors;
  int items_sent;
  int results_checked;
  int status_seen [5];
  int cycle_count;
  int out_hold;
  bit in_quiet;
  bit out_quiet;

  always #5 clk = ~clk;

  ordered_list_table_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) gap_len = 0;
    else if (r < 85) gap_len = $urandom_range(3, 1);
    else if (r < 97) gap_len = $urandom_range(10, 4);
    else gap_len = $urandom_range(40, 20);
  endfunction

  // applies one operation to the shadow list and returns the result it gives
  function automatic list_result_t list_apply(op_t op, logic [POS_W-1:0] pos,
                                              logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  p;
    int unsigned  j;
    bit           hit;
    r.sts  = STS_OK;
    r.rd   = '0;
    r.fidx = '0;
    p      = 32'(pos);
    hit    = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= CAP) r.sts = STS_FULL;
        else if (p > shadow_len) r.sts = STS_BADPOS;
        else begin
          // open a slot at p by moving the tail up
          for (j = shadow_len; j > p; j--) shadow_entries[j] = shadow_entries[j-1];
          shadow_entries[p] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) r.sts = STS_EMPTY;
        else if (p >= shadow_len) r.sts = STS_BADPOS;
        else begin
          // close the gap by moving the tail down
          for (j = p; j + 1 < shadow_len; j++) shadow_entries[j] = shadow_entries[j+1];
          shadow_len--;
        end
      end
      OP_READ: begin
        if (p < shadow_len) r.rd = shadow_entries[p];
        else r.sts = STS_BADPOS;
      end
      default: begin
        for (j = 0; j < shadow_len; j++) begin
          if (!hit && shadow_entries[j] == val) begin
            hit    = 1'b1;
            r.fidx = FIDX_W'(j);
          end
        end
        if (!hit) r.sts = STS_NOTFOUND;
      end
    endcase
    r.len = LEN_W'(shadow_len);
    if (shadow_len > peak_len) peak_len = shadow_len;
    return r;
  endfunction

  // drives one item, waits for its acceptance and queues what it should return
  task automatic send_item(input op_t op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input bit typed,
                           input list_result_t typed_res);
    list_result_t          r;
    logic [IN_TDATA_W-1:0] word;
    int                    g;
    word = '0;
    word[IN_FIELDS_W-1:0] = {val, pos, op};
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    // state advances even where the row types its own expectation
    r = list_apply(op, pos, val);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    items_sent++;
    g = in_quiet ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // holds the input idle until every queued result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // random item shaped by the traffic mix and the current shadow length
  task automatic pick_item(input mix_t mix, output op_t op,
                           output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
    int          r;
    int unsigned top;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:   op = r < 60 ? OP_INSERT : r < 75 ? OP_DELETE : r < 88 ? OP_READ : OP_FIND;
      MIX_SHRINK: op = r < 15 ? OP_INSERT : r < 65 ? OP_DELETE : r < 82 ? OP_READ : OP_FIND;
      MIX_STEADY: op = r < 30 ? OP_INSERT : r < 60 ? OP_DELETE : r < 80 ? OP_READ : OP_FIND;
      default:    op = op_t'($urandom_range(3));
    endcase
    // a small alphabet half the time so that finds meet duplicates
    if ($urandom_range(1) == 0) val = VAL_W'($urandom_range(7));
    else val = VAL_W'($urandom_range(255));
    if (mix == MIX_NOISE) begin
      pos = POS_W'($urandom_range(127));
    end else begin
      top = (op == OP_INSERT) ? shadow_len : ((shadow_len > 0) ? shadow_len - 1 : 0);
      r = $urandom_range(99);
      if (r < 15) pos = '0;
      else if (r < 30) pos = POS_W'(top);
      else if (r < 88) pos = POS_W'($urandom_range(top));
      else pos = POS_W'($urandom_range(CAP, shadow_len));
      // most finds look for something that is stored
      if (op == OP_FIND && shadow_len > 0 && $urandom_range(99) < 60)
        val = shadow_entries[$urandom_range(shadow_len - 1)];
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $realtime, name, exp_v, got_v);
      errors++;
    end
  endtask

  // output side: random stalls, with quiet stretches of none
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (!out_quiet && $urandom_range(99) < 30) begin
      out_hold   <= gap_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: every output item is matched with the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item %0h with nothing pending", $realtime, out_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 8'(exp_r.sts), 8'(out_tdata[STS_W-1:0]));
        check_field("read_value", exp_r.rd, out_tdata[STS_W +: VAL_W]);
        check_field("found_index", 8'(exp_r.fidx), 8'(out_tdata[STS_W+VAL_W +: FIDX_W]));
        check_field("list_length", 8'(exp_r.len),
                    8'(out_tdata[STS_W+VAL_W+FIDX_W +: LEN_W]));
        status_seen[exp_r.sts]++;
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("ordered_list_table_core: mismatch");
      $finish;
    end
  end

  initial begin
    list_result_t     typed_res;
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    mix_t             mix;
    int               r;
    int               ep_len;
    int               episode;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    out_hold    = 0;
    out_quiet   = 1'b0;
    in_quiet    = 1'b0;
    cycle_count = 0;
    errors      = 0;
    items_sent  = 0;
    results_checked = 0;
    shadow_len  = 0;
    peak_len    = 0;
    episode     = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].rpt; k++) begin
        typed_res.sts  = dir_rows[i].sts;
        typed_res.rd   = dir_rows[i].rd;
        typed_res.fidx = dir_rows[i].fidx;
        typed_res.len  = dir_rows[i].len;
        send_item(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val,
                  dir_rows[i].typed, typed_res);
      end
    end

    // random episodes: growth and shrink phases sweep the list between
    // empty and full, steady phases churn, noise sends any field values
    while (items_sent < RAND_ITEMS + 90) begin
      r = $urandom_range(99);
      mix = r < 30 ? MIX_GROW : r < 60 ? MIX_SHRINK : r < 88 ? MIX_STEADY : MIX_NOISE;
      ep_len = (mix == MIX_NOISE) ? $urandom_range(30, 10) : $urandom_range(160, 40);
      in_quiet = ($urandom_range(9) < 2);
      out_quiet <= ($urandom_range(9) < 2);
      // at least once, stop sending until the block has answered everything
      if (episode == 0 || $urandom_range(7) == 0) drain_results();
      repeat (ep_len) begin
        pick_item(mix, op, pos, val);
        send_item(op, pos, val, 1'b0, typed_res);
      end
      episode++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items over %0d random episodes, %0d results checked, peak length %0d",
             items_sent, episode, results_checked, peak_len);
    $display("status mix: ok %0d, full %0d, bad position %0d, empty %0d, not found %0d",
             status_seen[STS_OK], status_seen[STS_FULL], status_seen[STS_BADPOS],
             status_seen[STS_EMPTY], status_seen[STS_NOTFOUND]);
    if (errors == 0) begin
      $display("ordered_list_table_core: match");
    end else begin
      $display("%0d field errors", errors);
      $display("ordered_list_table_core: mismatch");
    end
    $finish;
  end

endmodule
